// ===== rtl/weighted_cluster_centroid_macros.svh =====
// assertion macros for the weighted cluster centroid checker
`ifndef WEIGHTED_CLUSTER_CENTROID_MACROS_SVH
`define WEIGHTED_CLUSTER_CENTROID_MACROS_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define WCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define WCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wcc_pkg.sv =====
// shared constants and types of the weighted cluster centroid block
`timescale 1ns / 1ps
`default_nettype none
package wcc_pkg;

    localparam int POS_BITS     = 16;
    localparam int HEIGHT_BITS  = 16;
    localparam int W_BITS       = 2 * HEIGHT_BITS;
    localparam int ID_BITS      = 16;
    localparam int KIND_BITS    = 3;
    localparam int AMP_BITS     = 22;
    localparam logic [AMP_BITS-1:0] AMP_MAX = '1;
    localparam int NUM_AXES     = 4;
    localparam int DEF_MAX_HITS = 64;
    localparam int QUEUE_DEPTH  = 4;
    localparam int IN_DATA_BITS = 6 * POS_BITS + HEIGHT_BITS + ID_BITS;
    localparam int OUT_USER_BITS = KIND_BITS + 1;

    // axis slots of the weighted sums
    localparam int AX_X  = 0;
    localparam int AX_Y  = 1;
    localparam int AX_CX = 2;
    localparam int AX_CY = 3;

    typedef struct packed {
        logic [NUM_AXES-1:0][POS_BITS-1:0] pos;
        logic [POS_BITS-1:0]               z;
        logic [POS_BITS-1:0]               cz;
        logic [HEIGHT_BITS-1:0]            height;
        logic [W_BITS-1:0]                 weight;
        logic [ID_BITS-1:0]                id;
        logic [KIND_BITS-1:0]              kind;
        logic                              last;
    } hit_t;

endpackage
`default_nettype wire

// ===== rtl/wcc_front.sv =====
// front end: accepts hits, squares the height and queues them
`timescale 1ns / 1ps
`default_nettype none
module wcc_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [wcc_pkg::IN_DATA_BITS-1:0]     s_tdata,
    input  wire logic [wcc_pkg::KIND_BITS-1:0]        s_tuser,
    input  wire logic                                 s_tlast,
    output logic                                      q_valid,
    input  wire logic                                 q_ready,
    output wcc_pkg::hit_t                             q_hit
);

    localparam int PTR_BITS = $clog2(wcc_pkg::QUEUE_DEPTH);
    localparam int P        = wcc_pkg::POS_BITS;

    wcc_pkg::hit_t           queue_reg [wcc_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]     wr_ptr_reg;
    logic [PTR_BITS-1:0]     rd_ptr_reg;
    logic [PTR_BITS:0]       fill_reg;
    wcc_pkg::hit_t           in_hit;
    logic                    push;
    logic                    pop;

    always_comb
    begin
        in_hit = '0;
        in_hit.pos[wcc_pkg::AX_X]  = s_tdata[0*P +: P];
        in_hit.pos[wcc_pkg::AX_Y]  = s_tdata[1*P +: P];
        in_hit.z                   = s_tdata[2*P +: P];
        in_hit.pos[wcc_pkg::AX_CX] = s_tdata[3*P +: P];
        in_hit.pos[wcc_pkg::AX_CY] = s_tdata[4*P +: P];
        in_hit.cz                  = s_tdata[5*P +: P];
        in_hit.height              = s_tdata[6*P +: wcc_pkg::HEIGHT_BITS];
        in_hit.id     = s_tdata[6*P + wcc_pkg::HEIGHT_BITS +: wcc_pkg::ID_BITS];
        in_hit.weight = in_hit.height * in_hit.height;
        in_hit.kind   = s_tuser;
        in_hit.last   = s_tlast;
    end

    assign s_tready = (fill_reg != (PTR_BITS+1)'(wcc_pkg::QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_hit    = queue_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PTR_BITS'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= PTR_BITS'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                fill_reg <= (PTR_BITS+1)'(fill_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                fill_reg <= (PTR_BITS+1)'(fill_reg - 1'b1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wcc_back.sv =====
// back end: weighted accumulation, serial division and result register
`timescale 1ns / 1ps
`default_nettype none
module wcc_back #(
    parameter int MAX_HITS = wcc_pkg::DEF_MAX_HITS,
    parameter int CNT_BITS = $clog2(MAX_HITS + 1),
    parameter int OUT_BITS = ((6 * wcc_pkg::POS_BITS + wcc_pkg::AMP_BITS
                              + wcc_pkg::ID_BITS + CNT_BITS + 7) / 8) * 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_valid,
    output logic                                      q_ready,
    input  wire wcc_pkg::hit_t                        q_hit,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [OUT_BITS-1:0]                       m_tdata,
    output logic [wcc_pkg::OUT_USER_BITS-1:0]         m_tuser
);

    localparam int P         = wcc_pkg::POS_BITS;
    localparam int HIT_BITS  = $clog2(MAX_HITS);
    localparam int SUM_BITS  = P + wcc_pkg::W_BITS + HIT_BITS;
    localparam int WSUM_BITS = wcc_pkg::W_BITS + HIT_BITS;
    localparam int PROD_BITS = P + wcc_pkg::W_BITS;
    localparam int BIT_BITS  = $clog2(SUM_BITS + 1);
    localparam int STEP_BITS = $clog2(wcc_pkg::NUM_AXES + 1);
    localparam int AX_BITS   = $clog2(wcc_pkg::NUM_AXES);
    localparam int AMPW      = wcc_pkg::AMP_BITS + 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL    = 6'b000010,
        S_DLOAD  = 6'b000100,
        S_DIV    = 6'b001000,
        S_DSTORE = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t                                state_reg;
    wcc_pkg::hit_t                         hit_reg;
    logic                                  acc_en_reg;
    logic [STEP_BITS-1:0]                  step_reg;
    logic signed [PROD_BITS-1:0]           prod_reg;
    logic signed [SUM_BITS-1:0]            sum_reg [wcc_pkg::NUM_AXES];
    logic [WSUM_BITS-1:0]                  wsum_reg;
    logic [wcc_pkg::AMP_BITS-1:0]          amp_reg;
    logic [wcc_pkg::HEIGHT_BITS-1:0]       peak_h_reg;
    logic [wcc_pkg::ID_BITS-1:0]           peak_id_reg;
    logic [P-1:0]                          z_reg;
    logic [P-1:0]                          cz_reg;
    logic [wcc_pkg::KIND_BITS-1:0]         kind_reg;
    logic [CNT_BITS-1:0]                   cnt_reg;
    logic [AX_BITS-1:0]                    ax_reg;
    logic [BIT_BITS-1:0]                   bit_reg;
    logic [SUM_BITS-1:0]                   dvd_reg;
    logic [WSUM_BITS-1:0]                  rem_reg;
    logic [P-1:0]                          quo_reg;
    logic                                  neg_reg;
    logic [P-1:0]                          mean_reg [wcc_pkg::NUM_AXES];
    logic                                  out_valid_reg;
    logic [OUT_BITS-1:0]                   out_data_reg;
    logic [wcc_pkg::OUT_USER_BITS-1:0]     out_user_reg;

    logic signed [P-1:0]                   mul_pos;
    logic signed [wcc_pkg::W_BITS:0]       mul_w;
    logic signed [PROD_BITS:0]             mul_full;
    logic [AMPW-1:0]                       amp_wide;
    logic                                  mul_done;
    logic [WSUM_BITS:0]                    trial;
    logic                                  fits;
    logic signed [SUM_BITS-1:0]            div_src;
    logic                                  zero_w;
    logic [P-1:0]                          out_mean [wcc_pkg::NUM_AXES];

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        mul_pos  = $signed(hit_reg.pos[step_reg[AX_BITS-1:0]]);
        mul_w    = $signed({1'b0, hit_reg.weight});
        mul_full = mul_pos * mul_w;
        amp_wide = {1'b0, amp_reg} + AMPW'(q_hit.height);
        mul_done = !acc_en_reg || (step_reg == STEP_BITS'(wcc_pkg::NUM_AXES));
        trial    = {rem_reg, dvd_reg[SUM_BITS-1]};
        fits     = (trial >= {1'b0, wsum_reg});
        div_src  = sum_reg[ax_reg];
        zero_w   = (wsum_reg == '0);
        for (int i = 0; i < wcc_pkg::NUM_AXES; i++)
        begin
            out_mean[i] = zero_w ? '0 : mean_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hit_reg       <= '0;
            acc_en_reg    <= 1'b0;
            step_reg      <= '0;
            prod_reg      <= '0;
            for (int i = 0; i < wcc_pkg::NUM_AXES; i++)
            begin
                sum_reg[i]  <= '0;
                mean_reg[i] <= '0;
            end
            wsum_reg      <= '0;
            amp_reg       <= '0;
            peak_h_reg    <= '0;
            peak_id_reg   <= '0;
            z_reg         <= '0;
            cz_reg        <= '0;
            kind_reg      <= '0;
            cnt_reg       <= '0;
            ax_reg        <= '0;
            bit_reg       <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else
        begin
            // the emit state handles the output register itself
            if (m_tready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        hit_reg  <= q_hit;
                        step_reg <= '0;
                        state_reg <= S_MUL;
                        acc_en_reg <= (cnt_reg < CNT_BITS'(MAX_HITS));
                        if (cnt_reg < CNT_BITS'(MAX_HITS))
                        begin
                            if (cnt_reg == '0)
                            begin
                                z_reg    <= q_hit.z;
                                cz_reg   <= q_hit.cz;
                                kind_reg <= q_hit.kind;
                            end
                            wsum_reg <= WSUM_BITS'(wsum_reg + WSUM_BITS'(q_hit.weight));
                            // amplitude sum saturates
                            if (amp_wide > {1'b0, wcc_pkg::AMP_MAX})
                            begin
                                amp_reg <= wcc_pkg::AMP_MAX;
                            end
                            else
                            begin
                                amp_reg <= amp_wide[wcc_pkg::AMP_BITS-1:0];
                            end
                            if (q_hit.height > peak_h_reg)
                            begin
                                peak_h_reg  <= q_hit.height;
                                peak_id_reg <= q_hit.id;
                            end
                            cnt_reg <= CNT_BITS'(cnt_reg + 1'b1);
                        end
                    end
                end
                S_MUL:
                begin
                    // multiply one axis while the previous product is added
                    if (acc_en_reg && step_reg != STEP_BITS'(wcc_pkg::NUM_AXES))
                    begin
                        prod_reg <= $signed(mul_full[PROD_BITS-1:0]);
                    end
                    if (acc_en_reg && step_reg != '0)
                    begin
                        sum_reg[AX_BITS'(step_reg - 1'b1)] <=
                            sum_reg[AX_BITS'(step_reg - 1'b1)] + SUM_BITS'(prod_reg);
                    end
                    step_reg <= STEP_BITS'(step_reg + 1'b1);
                    if (mul_done)
                    begin
                        ax_reg <= '0;
                        if (!hit_reg.last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (zero_w)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_DLOAD;
                        end
                    end
                end
                S_DLOAD:
                begin
                    neg_reg   <= div_src[SUM_BITS-1];
                    dvd_reg   <= div_src[SUM_BITS-1] ? SUM_BITS'(-div_src)
                                                     : SUM_BITS'(div_src);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    bit_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    if (fits)
                    begin
                        rem_reg <= WSUM_BITS'(trial - {1'b0, wsum_reg});
                    end
                    else
                    begin
                        rem_reg <= WSUM_BITS'(trial);
                    end
                    quo_reg <= {quo_reg[P-2:0], fits};
                    dvd_reg <= {dvd_reg[SUM_BITS-2:0], 1'b0};
                    bit_reg <= BIT_BITS'(bit_reg + 1'b1);
                    if (bit_reg == BIT_BITS'(SUM_BITS - 1))
                    begin
                        state_reg <= S_DSTORE;
                    end
                end
                S_DSTORE:
                begin
                    mean_reg[ax_reg] <= neg_reg ? P'(-quo_reg) : quo_reg;
                    if (ax_reg == AX_BITS'(wcc_pkg::NUM_AXES - 1))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        ax_reg    <= AX_BITS'(ax_reg + 1'b1);
                        state_reg <= S_DLOAD;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= OUT_BITS'({cnt_reg, peak_id_reg, amp_reg, cz_reg,
                                                    out_mean[wcc_pkg::AX_CY],
                                                    out_mean[wcc_pkg::AX_CX], z_reg,
                                                    out_mean[wcc_pkg::AX_Y],
                                                    out_mean[wcc_pkg::AX_X]});
                        out_user_reg  <= {zero_w, kind_reg};
                        for (int i = 0; i < wcc_pkg::NUM_AXES; i++)
                        begin
                            sum_reg[i] <= '0;
                        end
                        wsum_reg    <= '0;
                        amp_reg     <= '0;
                        peak_h_reg  <= '0;
                        peak_id_reg <= '0;
                        z_reg       <= '0;
                        cz_reg      <= '0;
                        kind_reg    <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/weighted_cluster_centroid.sv =====
// top level of the weighted cluster centroid block
//
//  channel  dir  tdata (low bit up)                                   tuser / tlast
//  s_*      in   hit_x, hit_y, hit_z, counter_x, counter_y,           module_kind / last_hit
//                counter_z, signal_height, detector_id
//  m_*      out  mean_x, mean_y, first_z, mean_counter_x,             cluster_kind,
//                mean_counter_y, first_counter_z, total_amplitude,    zero_weight_error
//                peak_detector_id, hit_count
//
//  a hit in the back end is popped from the four-entry queue in the idle state, then the
//  shared multiplier steps through the four position axes in the multiply state
//  a last hit then runs the serial divider on each axis in turn (load, divide, store),
//  or goes straight to the emit state when all heights are zero
//  hits past MAX_HITS leave the multiply state without a product and are not accumulated
//  the queue keeps taking hits until it is full while the back end divides or waits on m_tready
//  reset is asynchronous and leaves the block at cluster start
`timescale 1ns / 1ps
`default_nettype none
module weighted_cluster_centroid #(
    parameter int MAX_HITS = wcc_pkg::DEF_MAX_HITS,
    parameter int CNT_BITS = $clog2(MAX_HITS + 1),
    parameter int OUT_BITS = ((6 * wcc_pkg::POS_BITS + wcc_pkg::AMP_BITS
                              + wcc_pkg::ID_BITS + CNT_BITS + 7) / 8) * 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // hit_x, hit_y, hit_z, counter_x, counter_y, counter_z, signal_height, detector_id
    input  wire logic [wcc_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // module_kind
    input  wire logic [wcc_pkg::KIND_BITS-1:0]        s_tuser,
    input  wire logic                                 s_tlast,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // mean_x, mean_y, first_z, mean_counter_x, mean_counter_y, first_counter_z,
    // total_amplitude, peak_detector_id, hit_count, zero pad
    output logic [OUT_BITS-1:0]                       m_tdata,
    // cluster_kind, zero_weight_error
    output logic [wcc_pkg::OUT_USER_BITS-1:0]         m_tuser
);

    logic           q_valid;
    logic           q_ready;
    wcc_pkg::hit_t  q_hit;

    wcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_hit    (q_hit)
    );

    wcc_back #(
        .MAX_HITS (MAX_HITS),
        .CNT_BITS (CNT_BITS),
        .OUT_BITS (OUT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_hit    (q_hit),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/wcc_checker.sv =====
// port-level checks of the weighted cluster centroid block
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_cluster_centroid_macros.svh"
module wcc_checker #(
    parameter int MAX_HITS = wcc_pkg::DEF_MAX_HITS,
    parameter int CNT_BITS = $clog2(MAX_HITS + 1),
    parameter int OUT_BITS = ((6 * wcc_pkg::POS_BITS + wcc_pkg::AMP_BITS
                              + wcc_pkg::ID_BITS + CNT_BITS + 7) / 8) * 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic [OUT_BITS-1:0]                  m_tdata,
    input  wire logic [wcc_pkg::OUT_USER_BITS-1:0]    m_tuser
);

    localparam int P       = wcc_pkg::POS_BITS;
    localparam int CNT_LSB = 6 * P + wcc_pkg::AMP_BITS + wcc_pkg::ID_BITS;
    localparam int PID_LSB = 6 * P + wcc_pkg::AMP_BITS;

    logic err;
    assign err = m_tuser[wcc_pkg::KIND_BITS];

    // zero weight forces all four means to zero
    `WCC_ASSERT_NOW(a_zero_means, m_tvalid && err,
        m_tdata[2*P-1:0] == '0 && m_tdata[5*P-1:3*P] == '0, "means not zero on zero weight")
    // no hit beats a zero peak
    `WCC_ASSERT_NOW(a_zero_peak, m_tvalid && err,
        m_tdata[PID_LSB +: wcc_pkg::ID_BITS] == '0, "peak id set on zero weight")
    // every cluster has at least one hit
    `WCC_ASSERT_NOW(a_count_nonzero, m_tvalid,
        m_tdata[CNT_LSB +: CNT_BITS] != '0, "cluster with no hits")
    // a stalled result holds
    `WCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

endmodule

bind weighted_cluster_centroid wcc_checker #(
    .MAX_HITS (MAX_HITS),
    .CNT_BITS (CNT_BITS),
    .OUT_BITS (OUT_BITS)
) u_wcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== verif/tb_weighted_cluster_centroid.sv =====
// self-checking testbench of the weighted cluster centroid block
`timescale 1ns / 1ps
`default_nettype none
module tb_weighted_cluster_centroid;

    localparam int MAXH = wcc_pkg::DEF_MAX_HITS;
    localparam int CNTB = $clog2(MAXH + 1);
    localparam int OUTB = ((6 * wcc_pkg::POS_BITS + wcc_pkg::AMP_BITS + wcc_pkg::ID_BITS
                            + CNTB + 7) / 8) * 8;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] x, y, z, cx, cy, cz, height, id;
        logic [2:0]  kind;
        logic        last;
    } hit_item_t;

    typedef struct packed {
        logic [15:0] mx, my, fz, mcx, mcy, fcz;
        logic [21:0] amp;
        logic [15:0] pid;
        logic [6:0]  cnt;
        logic [2:0]  kind;
        logic        err;
    } centroid_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [wcc_pkg::IN_DATA_BITS-1:0] s_tdata = '0;
    logic [wcc_pkg::KIND_BITS-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUTB-1:0] m_tdata;
    logic [wcc_pkg::OUT_USER_BITS-1:0] m_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    centroid_t expected_centroids[$];

    // running cluster sums
    longint acc_wx, acc_wy, acc_wcx, acc_wcy, acc_w;
    int unsigned acc_amp, acc_peak, acc_pid, acc_cnt;
    logic [15:0] acc_z, acc_cz;
    logic [2:0] acc_kind;

    weighted_cluster_centroid dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 clk = ~clk;

    task automatic clear_cluster();
        acc_wx = 0; acc_wy = 0; acc_wcx = 0; acc_wcy = 0; acc_w = 0;
        acc_amp = 0; acc_peak = 0; acc_pid = 0; acc_cnt = 0;
        acc_z = '0; acc_cz = '0; acc_kind = '0;
    endtask

    function automatic logic [15:0] centroid_div(longint num);
        longint q;
        if (acc_w <= 0)
            return 16'd0;
        q = num / acc_w;
        return q[15:0];
    endfunction

    task automatic predict_hit(hit_item_t h);
        longint w;
        centroid_t r;
        w = longint'(h.height) * longint'(h.height);
        if (acc_cnt < MAXH)
        begin
            if (acc_cnt == 0)
            begin
                acc_z = h.z; acc_cz = h.cz; acc_kind = h.kind;
            end
            acc_wx += longint'($signed(h.x)) * w;
            acc_wy += longint'($signed(h.y)) * w;
            acc_wcx += longint'($signed(h.cx)) * w;
            acc_wcy += longint'($signed(h.cy)) * w;
            acc_w += w;
            acc_amp += h.height;
            if (acc_amp > 4194303)
                acc_amp = 4194303;
            if (h.height > acc_peak)
            begin
                acc_peak = h.height;
                acc_pid = h.id;
            end
            acc_cnt++;
        end
        if (h.last)
        begin
            r.err = (acc_w == 0);
            r.mx = centroid_div(acc_wx);
            r.my = centroid_div(acc_wy);
            r.mcx = centroid_div(acc_wcx);
            r.mcy = centroid_div(acc_wcy);
            r.fz = acc_z;
            r.fcz = acc_cz;
            r.amp = acc_amp[21:0];
            r.pid = acc_pid[15:0];
            r.kind = acc_kind;
            r.cnt = acc_cnt[6:0];
            expected_centroids = {expected_centroids, r};
            clear_cluster();
        end
    endtask

    // valid stays up after an accept until the next item or an idle cycle replaces it
    task automatic send_hit(hit_item_t h);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {h.id, h.height, h.cz, h.cy, h.cx, h.z, h.y, h.x};
        s_tuser <= h.kind;
        s_tlast <= h.last;
        predict_hit(h);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic hit_item_t random_hit(logic last);
        hit_item_t h;
        h = hit_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(4))
            0: h.height = 16'd0;
            1: h.height = 16'hffff;
            2: h.height = 16'($urandom_range(15));
            default: ;
        endcase
        h.last = last;
        return h;
    endfunction

    task automatic send_cluster(int n);
        for (int i = 0; i < n; i++)
            send_hit(random_hit(i == n - 1));
    endtask

    always @(posedge clk)
    begin
        centroid_t got, exp_r;
        m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (m_tvalid && m_tready)
        begin
            got = {m_tdata[6*16+22+16+CNTB-1:0], m_tuser[0 +: 3], m_tuser[3]};
            got.cnt = 7'(m_tdata[6*16+22+16 +: CNTB]);
            got.mx = m_tdata[15:0];   got.my = m_tdata[31:16];
            got.fz = m_tdata[47:32];  got.mcx = m_tdata[63:48];
            got.mcy = m_tdata[79:64]; got.fcz = m_tdata[95:80];
            got.amp = m_tdata[117:96]; got.pid = m_tdata[133:118];
            got.kind = m_tuser[2:0]; got.err = m_tuser[3];
            if (expected_centroids.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cluster result %h", got);
            end
            else
            begin
                exp_r = expected_centroids.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cluster mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        hit_item_t h;
        // all heights zero
        h = '0; h.x = 16'h8000; h.z = 16'h7fff; h.cz = 16'h8000; h.kind = 3'd7;
        send_hit(h);
        h.x = 16'h7fff; h.last = 1'b1; send_hit(h);
        // single extreme hit
        h = '1; send_hit(h);
        h = '0; h.x = 16'h8000; h.y = 16'h8000; h.cx = 16'h8000; h.cy = 16'h8000;
        h.height = 16'hffff; h.id = 16'hffff; h.last = 1'b1; send_hit(h);
        // tie on peak, first wins
        h = '0; h.height = 16'd5; h.id = 16'd11; h.x = -16'sd3; send_hit(h);
        h.id = 16'd22; h.x = 16'd4; h.last = 1'b1; send_hit(h);
        // negative mean truncates toward zero
        h = '0; h.height = 16'd1; h.x = -16'sd1; send_hit(h);
        h.x = 16'd0; h.height = 16'd1; h.last = 1'b1; send_hit(h);
        for (int k = 0; k < 8; k++)
            send_hit(random_hit(1'b1));
    endtask

    // more than MAX_HITS hits, amplitude sum near saturation
    task automatic test_overflow();
        hit_item_t h;
        for (int i = 0; i < MAXH + 3; i++)
        begin
            h = random_hit(i == MAXH + 2);
            h.height = 16'hffff - 16'(i);
            send_hit(h);
        end
    endtask

    task automatic test_random(int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget)
        begin
            n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            send_cluster(n);
            sent += n;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_centroids.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        clear_cluster();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        send_idle_pct = 36; recv_idle_pct = 88;
        test_random(600);
        send_idle_pct = 88; recv_idle_pct = 36;
        test_random(600);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(600);
        drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/wcc_pkg.sv
rtl/wcc_front.sv
rtl/wcc_back.sv
rtl/weighted_cluster_centroid.sv
rtl/wcc_checker.sv
verif/tb_weighted_cluster_centroid.sv
